// ===== design/mjd_pkg.sv =====
package mjd_pkg;

  localparam int unsigned CurW   = 16;
  localparam int unsigned TimeW  = 22;
  localparam int unsigned StampW = 32;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ProdW  = CurW + PctW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = TimeW;

  localparam logic [PctW-1:0] PctFull = PctW'(100);

  // floor(p / 100) = (p * RecipK) >> RecipShift, exact for p < 2^ProdW
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipKW    = 24;
  localparam logic [RecipKW-1:0] RecipK = RecipKW'(((64'd1 << RecipShift) + 64'd99) / 64'd100);
  localparam int unsigned RecipProdW = RecipShift + CurW;

  typedef enum logic [3:0] {
    MS_IDLE        = 4'd0,
    MS_HOME_MAN    = 4'd1,
    MS_HOME_AUTO   = 4'd2,
    MS_PLUNGE_MAN  = 4'd3,
    MS_PLUNGE_AUTO = 4'd4,
    MS_STOP        = 4'd5,
    MS_JAMMED      = 4'd6,
    MS_RESET       = 4'd7,
    MS_RECORD      = 4'd8,
    MS_REPLAY      = 4'd9,
    MS_FILL        = 4'd10,
    MS_POSTFLOW    = 4'd11
  } main_state_e;

  typedef enum logic [2:0] {
    FP_NONE     = 3'd0,
    FP_PLUNGING = 3'd1,
    FP_PLUNGED  = 3'd2,
    FP_HOMING   = 3'd3,
    FP_HOMED    = 3'd4
  } fill_phase_e;

  typedef enum logic [1:0] {
    PF_NONE     = 2'd0,
    PF_STOPPING = 2'd1,
    PF_STARTING = 2'd2,
    PF_COMPLETE = 2'd3
  } post_flow_phase_e;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_JAM          = 3'd1,
    ACT_POSTFLOW     = 3'd2,
    ACT_FILL_PLUNGED = 3'd3,
    ACT_FILL_HOMED   = 3'd4
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_JAM_LIMIT    = 3'd0,
    CFG_PF_LIMIT     = 3'd1,
    CFG_PLUNGE_TIME  = 3'd2,
    CFG_HOMING_TIME  = 3'd3,
    CFG_UNIV_TIME    = 3'd4,
    CFG_PF_ENABLE    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic homing;
    logic plunging;
    logic plunge_auto;
    logic pf_start;
    logic fill_plunge;
    logic fill_home;
  } mode_t;

endpackage

// ===== design/mjd_pre.sv =====
module mjd_pre import mjd_pkg::*; (
  input  logic [3:0]       main_state_i,
  input  logic [2:0]       fill_phase_i,
  input  logic [1:0]       post_flow_phase_i,
  input  logic [PctW-1:0]  torque_pct_i,
  input  logic [CurW-1:0]  jam_limit_i,
  output mode_t            mode_o,
  output logic [ProdW-1:0] product_o
);

  logic [PctW-1:0] scale;

  always_comb begin
    mode_o.homing      = (main_state_i == MS_HOME_MAN) || (main_state_i == MS_HOME_AUTO);
    mode_o.plunging    = (main_state_i == MS_PLUNGE_MAN) || (main_state_i == MS_PLUNGE_AUTO) ||
                         (main_state_i == MS_RECORD);
    mode_o.plunge_auto = (main_state_i == MS_PLUNGE_AUTO);
    mode_o.pf_start    = (main_state_i == MS_POSTFLOW) && (post_flow_phase_i == PF_STARTING);
    mode_o.fill_plunge = (main_state_i == MS_FILL) && (fill_phase_i == FP_PLUNGING);
    mode_o.fill_home   = (main_state_i == MS_FILL) && (fill_phase_i == FP_HOMING);
  end

  assign scale     = (torque_pct_i <= PctFull) ? (PctFull - torque_pct_i) : '0;
  assign product_o = ProdW'(jam_limit_i) * ProdW'(scale);

endmodule

// ===== design/motor_jam_detector.sv =====
// Channel | Direction | Handshake               | Payload
// poll    | in        | in_valid_i / in_stall_o | now_ms_i, read_ok_i, current_ma_i, drive_fault_i,
//         |           |                         | main_state_i, fill_phase_i, post_flow_phase_i,
//         |           |                         | torque_pct_i
// result  | out       | out_valid_o / out_stall_i | action_o, over_limit_o, active_limit_ma_o
// config  | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled.
// Stages: input register, jam x scale product, reciprocal divide by 100 + timer logic.
// rst_ni clears valids, the over-limit timer and all config registers.
// A stalled output holds; stages behind it keep filling until all are full.
module motor_jam_detector import mjd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [StampW-1:0]   now_ms_i,
  input  logic                read_ok_i,
  input  logic [CurW-1:0]     current_ma_i,
  input  logic                drive_fault_i,
  input  logic [3:0]          main_state_i,
  input  logic [2:0]          fill_phase_i,
  input  logic [1:0]          post_flow_phase_i,
  input  logic [PctW-1:0]     torque_pct_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          action_o,
  output logic                over_limit_o,
  output logic [CurW-1:0]     active_limit_ma_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // config
  logic [CurW-1:0]  jam_lim_q, pf_lim_q;
  logic [TimeW-1:0] plunge_t_q, homing_t_q, univ_t_q;
  logic             pf_en_q;

  // stage 1
  logic              s1_vld_q;
  logic [StampW-1:0] s1_now_q;
  logic              s1_ok_q, s1_fault_q;
  logic [CurW-1:0]   s1_cur_q;
  logic [3:0]        s1_ms_q;
  logic [2:0]        s1_fp_q;
  logic [1:0]        s1_pf_q;
  logic [PctW-1:0]   s1_tq_q;

  // stage 2
  logic              s2_vld_q;
  logic [StampW-1:0] s2_now_q;
  logic              s2_ok_q, s2_fault_q;
  logic [CurW-1:0]   s2_cur_q;
  mode_t             s2_mode_q;
  logic [ProdW-1:0]  s2_prod_q;

  // output
  logic              out_vld_q;
  action_e           act_q;
  logic              ovl_q;
  logic [CurW-1:0]   lim_q;

  // timer state
  logic              armed_q, armed_d;
  logic [StampW-1:0] start_q, start_d;

  logic ready_out, ready2, ready1, accept, adv1, adv2;

  mode_t            s1_mode;
  logic [ProdW-1:0] s1_prod;

  logic [RecipProdW-1:0] recip_prod;
  logic [CurW-1:0]       scaled_lim;
  logic                  run;
  logic [CurW-1:0]       lim;
  logic [StampW-1:0]     elapsed;
  logic [TimeW-1:0]      target;
  action_e               act_d;
  logic [CurW-1:0]       lim_d;

  assign ready_out  = !out_vld_q || !out_stall_i;
  assign adv2       = s2_vld_q && ready_out;
  assign ready2     = !s2_vld_q || ready_out;
  assign adv1       = s1_vld_q && ready2;
  assign ready1     = !s1_vld_q || ready2;
  assign accept     = in_valid_i && ready1;
  assign in_stall_o = !ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jam_lim_q  <= '0;
      pf_lim_q   <= '0;
      plunge_t_q <= '0;
      homing_t_q <= '0;
      univ_t_q   <= '0;
      pf_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_JAM_LIMIT:   jam_lim_q  <= cfg_data_i[CurW-1:0];
        CFG_PF_LIMIT:    pf_lim_q   <= cfg_data_i[CurW-1:0];
        CFG_PLUNGE_TIME: plunge_t_q <= cfg_data_i;
        CFG_HOMING_TIME: homing_t_q <= cfg_data_i;
        CFG_UNIV_TIME:   univ_t_q   <= cfg_data_i;
        CFG_PF_ENABLE:   pf_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mjd_pre u_pre (
    .main_state_i      (s1_ms_q),
    .fill_phase_i      (s1_fp_q),
    .post_flow_phase_i (s1_pf_q),
    .torque_pct_i      (s1_tq_q),
    .jam_limit_i       (jam_lim_q),
    .mode_o            (s1_mode),
    .product_o         (s1_prod)
  );

  assign recip_prod = RecipProdW'(s2_prod_q) * RecipProdW'(RecipK);
  assign scaled_lim = recip_prod[RecipProdW-1:RecipShift];

  always_comb begin
    run = s2_mode_q.homing || s2_mode_q.plunging || s2_mode_q.pf_start ||
          s2_mode_q.fill_plunge || s2_mode_q.fill_home;
    if (s2_mode_q.pf_start) begin
      lim = pf_lim_q;
    end else if (s2_mode_q.plunging || s2_mode_q.fill_plunge) begin
      lim = scaled_lim;
    end else begin
      lim = jam_lim_q;
    end
    target  = (s2_mode_q.plunging || s2_mode_q.pf_start || s2_mode_q.fill_plunge) ?
              plunge_t_q : homing_t_q;
    start_d = armed_q ? start_q : s2_now_q;
    elapsed = s2_now_q - start_d;

    armed_d = armed_q;
    act_d   = ACT_NONE;
    lim_d   = '0;
    priority if (!s2_ok_q) begin
      act_d = ACT_NONE;
    end else if (s2_fault_q) begin
      act_d = ACT_JAM;
    end else if (!run) begin
      armed_d = 1'b0;
    end else if (s2_cur_q < lim) begin
      armed_d = 1'b0;
      lim_d   = lim;
    end else begin
      armed_d = 1'b1;
      lim_d   = lim;
      if (elapsed > StampW'(univ_t_q)) begin
        act_d = ACT_JAM;
      end else if ((target != '0) && (elapsed > StampW'(target))) begin
        priority if (s2_mode_q.plunge_auto && pf_en_q) begin
          act_d = ACT_POSTFLOW;
        end else if (s2_mode_q.fill_plunge) begin
          act_d   = ACT_FILL_PLUNGED;
          armed_d = 1'b0;
        end else if (s2_mode_q.fill_home) begin
          act_d   = ACT_FILL_HOMED;
          armed_d = 1'b0;
        end else begin
          act_d = ACT_JAM;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      armed_q   <= 1'b0;
      start_q   <= '0;
    end else begin
      s1_vld_q  <= accept || (s1_vld_q && !adv1);
      s2_vld_q  <= adv1 || (s2_vld_q && !adv2);
      out_vld_q <= adv2 || (out_vld_q && !ready_out);
      if (adv2) begin
        armed_q <= armed_d;
        start_q <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_now_q   <= now_ms_i;
      s1_ok_q    <= read_ok_i;
      s1_cur_q   <= current_ma_i;
      s1_fault_q <= drive_fault_i;
      s1_ms_q    <= main_state_i;
      s1_fp_q    <= fill_phase_i;
      s1_pf_q    <= post_flow_phase_i;
      s1_tq_q    <= torque_pct_i;
    end
    if (adv1) begin
      s2_now_q   <= s1_now_q;
      s2_ok_q    <= s1_ok_q;
      s2_fault_q <= s1_fault_q;
      s2_cur_q   <= s1_cur_q;
      s2_mode_q  <= s1_mode;
      s2_prod_q  <= s1_prod;
    end
    if (adv2) begin
      act_q <= act_d;
      ovl_q <= armed_d;
      lim_q <= lim_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign action_o          = act_q;
  assign over_limit_o      = ovl_q;
  assign active_limit_ma_o = lim_q;

  a_fill_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ((act_q == ACT_FILL_PLUNGED) || (act_q == ACT_FILL_HOMED)) |-> !ovl_q)
    else $error("fill advance left timer armed");

  a_postflow_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (act_q == ACT_POSTFLOW) |-> ovl_q)
    else $error("post-flow request without armed timer");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv2 |=> $stable(armed_q) && $stable(start_q))
    else $error("timer state changed without an item");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s2_vld_q && out_vld_q && out_stall_i |-> in_stall_o)
    else $error("input taken while pipeline full");

  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s2_vld_q))
    else $error("result without an item in flight");

endmodule
